### design/lces_pkg.sv
// shared types and constants of the looped clip event scheduler
`timescale 1ns / 1ps
`default_nettype none

package lces_pkg;

  // internal time width: block and clip arithmetic never leaves this range
  localparam int TW       = 52;
  localparam int POSW     = 48;
  localparam int LENW     = 40;
  localparam int MSGW     = 24;
  localparam int OFFW     = 16;
  localparam int SPW      = 17;
  localparam int TOTW     = 9;
  localparam int CSW      = 3;
  localparam int ESW      = 8;
  localparam int KINDW    = 2;
  localparam int DVW      = 49;
  localparam int SPAN_MAX = 65536;
  localparam int QDEPTH   = 2;

  typedef enum logic [KINDW-1:0] {
    KIND_CLIP  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_SCHED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_CLIP,
    OP_EVENT,
    OP_SCHED
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [CSW-1:0]          clip_slot;
    logic [ESW-1:0]          event_slot;
    logic signed [POSW-1:0]  position;
    logic [SPW-1:0]          span;
    logic [LENW-1:0]         len;
    logic [LENW-1:0]         ev_pos;
    logic [MSGW-1:0]         msg;
    logic                    loop_en;
    logic                    mute_en;
    logic [TOTW-1:0]         total;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

  typedef struct packed {
    logic            clear;
    logic            ins;
    logic            emit;
    logic [OFFW-1:0] off;
    logic [MSGW-1:0] msg;
  } srt_req_t;

  typedef struct packed {
    logic drop;
    logic done;
  } srt_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP,
    ST_DIV,
    ST_ITER,
    ST_ITER2,
    ST_ITER3,
    ST_BS,
    ST_BS_RD,
    ST_SCAN,
    ST_SCAN_RD,
    ST_KEEP,
    ST_NEXT_ITER,
    ST_NEXT_CLIP,
    ST_EMIT,
    ST_WAIT
  } bk_state_e;

endpackage

`default_nettype wire

### design/lces_front.sv
// request classifier: range checks, saturation and command build
`timescale 1ns / 1ps
`default_nettype none

module lces_front import lces_pkg::*; #(
  parameter int NUM_CLIPS       = 8,
  parameter int EVENTS_PER_CLIP = 256
) (
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [KINDW-1:0]       kind_i,
  input  wire logic [CSW-1:0]         clip_slot_i,
  input  wire logic [ESW-1:0]         event_slot_i,
  input  wire logic signed [POSW-1:0] position_i,
  input  wire logic [LENW-1:0]        span_i,
  input  wire logic [LENW-1:0]        event_position_i,
  input  wire logic [MSGW-1:0]        event_bytes_i,
  input  wire logic                   loop_enable_i,
  input  wire logic                   mute_enable_i,
  input  wire logic [TOTW-1:0]        event_total_i,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output cmd_t                        cmd_o
);

  logic keep;

  always_comb begin
    keep             = 1'b0;
    cmd_o.op         = OP_SCHED;
    cmd_o.clip_slot  = clip_slot_i;
    cmd_o.event_slot = event_slot_i;
    cmd_o.position   = position_i;
    cmd_o.len        = span_i;
    cmd_o.ev_pos     = event_position_i;
    cmd_o.msg        = event_bytes_i;
    cmd_o.loop_en    = loop_enable_i;
    cmd_o.mute_en    = mute_enable_i;
    // long blocks clamp so every offset fits the offset field
    if (span_i > LENW'(SPAN_MAX)) begin
      cmd_o.span = SPW'(SPAN_MAX);
    end else begin
      cmd_o.span = span_i[SPW-1:0];
    end
    if (int'(event_total_i) > EVENTS_PER_CLIP) begin
      cmd_o.total = TOTW'(EVENTS_PER_CLIP);
    end else begin
      cmd_o.total = event_total_i;
    end
    case (kind_i)
      KIND_CLIP: begin
        cmd_o.op = OP_CLIP;
        keep     = int'(clip_slot_i) < NUM_CLIPS;
      end
      KIND_EVENT: begin
        cmd_o.op = OP_EVENT;
        keep     = (int'(clip_slot_i) < NUM_CLIPS) && (int'(event_slot_i) < EVENTS_PER_CLIP);
      end
      KIND_SCHED: begin
        cmd_o.op = OP_SCHED;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

### design/lces_fifo.sv
// two entry command queue between classifier and engine
`timescale 1ns / 1ps
`default_nettype none

module lces_fifo import lces_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output q_sts_t    sts_o
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNW = $clog2(QDEPTH + 1);

  cmd_t           mem_q [QDEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CNW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  assign cmd_o       = mem_q[rd_q];
  assign sts_o.full  = cnt_q == CNW'(QDEPTH);
  assign sts_o.empty = cnt_q == '0;

endmodule

`default_nettype wire

### design/lces_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module lces_div import lces_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVW-1:0]   dividend_i,
  input  wire logic [LENW-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DVW-1:0]        quot_o,
  output logic [LENW-1:0]       rem_o
);

  localparam int DCW = $clog2(DVW + 1);

  logic           busy_q, done_q;
  logic [DCW-1:0] cnt_q;
  logic [DVW-1:0] quo_q;
  logic [LENW:0]  rem_q;
  logic [LENW-1:0] dsr_q;
  logic [LENW:0]  rem_sh, rem_nx;
  logic           ge;

  always_comb begin
    rem_sh = {rem_q[LENW-1:0], quo_q[DVW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCW'(DVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DCW'(1);
        if (cnt_q == DCW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[LENW-1:0];

endmodule

`default_nettype wire

### design/lces_sorter.sv
// sorted result list with cap, drained through an output register
`timescale 1ns / 1ps
`default_nettype none

module lces_sorter import lces_pkg::*; #(
  parameter int MAX_BLOCK_EVENTS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire srt_req_t   req_i,
  output srt_sts_t        sts_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [MSGW-1:0] out_message_o,
  output logic [OFFW-1:0] block_offset_o,
  output logic            has_event_o,
  output logic            overflowed_o,
  output logic            last_o
);

  localparam int MAXN = MAX_BLOCK_EVENTS;
  localparam int NW   = $clog2(MAXN + 1);

  logic [OFFW-1:0] off_q [MAXN];
  logic [MSGW-1:0] msg_q [MAXN];
  logic [OFFW-1:0] ins_off [MAXN];
  logic [MSGW-1:0] ins_msg [MAXN];
  logic [OFFW-1:0] nxt_off [MAXN];
  logic [MSGW-1:0] nxt_msg [MAXN];
  logic [MAXN-1:0] gt, wr;
  logic [NW-1:0]   n_q;
  logic            ovf_q, emit_q, sent_q, vld_q;
  logic            full, drop, take, pop_head, load_term, do_ins;

  assign full     = n_q == NW'(MAXN);
  assign drop     = full && (req_i.off >= off_q[MAXN-1]);
  assign do_ins   = req_i.ins && !drop;
  assign take     = !vld_q || !out_stall_i;
  assign pop_head = emit_q && take && (n_q != '0);
  assign load_term = emit_q && take && (n_q == '0) && !sent_q;

  // each cell decides on its own: keep, take the new entry, take its left neighbor, or on a pop take its right neighbor
  for (genvar i = 0; i < MAXN; i++) begin : g_cell
    assign gt[i] = (NW'(i) < n_q) && (off_q[i] > req_i.off);
    if (i == 0) begin : g_head
      assign ins_off[i] = req_i.off;
      assign ins_msg[i] = req_i.msg;
      assign wr[i]      = gt[i] || (n_q == '0);
    end else begin : g_body
      assign ins_off[i] = gt[i-1] ? off_q[i-1] : req_i.off;
      assign ins_msg[i] = gt[i-1] ? msg_q[i-1] : req_i.msg;
      assign wr[i]      = gt[i] || gt[i-1] || (n_q == NW'(i));
    end
    if (i == MAXN - 1) begin : g_tail
      assign nxt_off[i] = '0;
      assign nxt_msg[i] = '0;
    end else begin : g_mid
      assign nxt_off[i] = off_q[i+1];
      assign nxt_msg[i] = msg_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (pop_head) begin
        off_q[i] <= nxt_off[i];
        msg_q[i] <= nxt_msg[i];
      end else if (do_ins && wr[i]) begin
        off_q[i] <= ins_off[i];
        msg_q[i] <= ins_msg[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      ovf_q  <= 1'b0;
      emit_q <= 1'b0;
      sent_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      if (req_i.clear) begin
        n_q   <= '0;
        ovf_q <= 1'b0;
      end else if (req_i.ins) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          n_q <= n_q + NW'(1);
        end
      end else if (pop_head) begin
        n_q <= n_q - NW'(1);
      end
      if (req_i.emit) begin
        emit_q <= 1'b1;
        sent_q <= 1'b0;
      end else if (pop_head) begin
        sent_q <= 1'b1;
        if (n_q == NW'(1)) begin
          emit_q <= 1'b0;
        end
      end else if (emit_q && take) begin
        emit_q <= 1'b0;
      end
      if (take) begin
        vld_q <= pop_head || load_term;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_head) begin
      out_message_o  <= msg_q[0];
      block_offset_o <= off_q[0];
      has_event_o    <= 1'b1;
      last_o         <= n_q == NW'(1);
      overflowed_o   <= (n_q == NW'(1)) && ovf_q;
    end else if (load_term) begin
      out_message_o  <= '0;
      block_offset_o <= '0;
      has_event_o    <= 1'b0;
      last_o         <= 1'b1;
      overflowed_o   <= 1'b0;
    end
  end

  assign out_valid_o = vld_q;
  assign sts_o.drop  = drop;
  assign sts_o.done  = !emit_q;

endmodule

`default_nettype wire

### design/lces_back.sv
// engine: clip table, event memory and the clip, iteration and event walk
`timescale 1ns / 1ps
`default_nettype none

module lces_back import lces_pkg::*; #(
  parameter int NUM_CLIPS       = 8,
  parameter int EVENTS_PER_CLIP = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cmd_t     cmd_i,
  input  wire q_sts_t   q_sts_i,
  output logic          pop_o,
  output srt_req_t      srt_req_o,
  input  wire srt_sts_t srt_sts_i
);

  localparam int CW    = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
  localparam int DEPTH = NUM_CLIPS * EVENTS_PER_CLIP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = LENW + MSGW;
  localparam logic [CW-1:0] LAST_CLIP = CW'(NUM_CLIPS - 1);

  function automatic logic signed [TW-1:0] s2t(logic signed [POSW-1:0] v);
    return signed'({{(TW-POSW){v[POSW-1]}}, v});
  endfunction

  function automatic logic signed [TW-1:0] u2t(logic [LENW-1:0] v);
    return signed'({{(TW-LENW){1'b0}}, v});
  endfunction

  bk_state_e state_q, state_d;

  // clip descriptor table
  logic signed [POSW-1:0] cs_tab_q   [NUM_CLIPS];
  logic [LENW-1:0]        len_tab_q  [NUM_CLIPS];
  logic                   loop_tab_q [NUM_CLIPS];
  logic                   mute_tab_q [NUM_CLIPS];
  logic [TOTW-1:0]        n_tab_q    [NUM_CLIPS];

  logic [EW-1:0] ev_mem [DEPTH];
  logic [EW-1:0] rd_q;

  logic [CW-1:0]          c_q, wr_clip;
  logic signed [TW-1:0]   rs_q, re_q, cs_q, len_q, is_q, d_q, e_q, ls_q, le_q, rel_q;
  logic [SPW-1:0]         cnt_q;
  logic                   loop_q;
  logic [TOTW-1:0]        n_q, lo_q, hi_q, k_q, mid_q, mid_c, slot;
  logic [MSGW-1:0]        msg_q;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic                   tab_we, mem_we, div_start, div_done;
  logic [DVW-1:0]         div_quo;
  logic [LENW-1:0]        div_rem;
  logic signed [TW-1:0]   cs_rd, eo;
  logic                   skip_clip, need_div, iter_go, iter_empty, in_rng, rel_ok;

  lces_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DVW'(rs_q - cs_rd)),
    .divisor_i  (len_tab_q[c_q]),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  // conditions shared by next state, outputs and datapath
  always_comb begin
    cs_rd      = s2t(cs_tab_q[c_q]);
    skip_clip  = mute_tab_q[c_q] || (len_tab_q[c_q] == '0);
    need_div   = loop_tab_q[c_q] && (rs_q > cs_rd);
    iter_go    = !loop_q || ((is_q - len_q) < re_q);
    iter_empty = (le_q < ls_q) || ((le_q == ls_q) && !((ls_q == len_q) && (le_q == len_q)));
    eo         = u2t(rd_q[EW-1:MSGW]);
    in_rng     = (eo < le_q) || ((eo == len_q) && (le_q == len_q));
    rel_ok     = (rel_q >= 0) && (rel_q < signed'(TW'(cnt_q)));
    mid_c      = TOTW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_sts_i.empty && (cmd_i.op == OP_SCHED)) begin
          state_d = (cmd_i.span == '0) ? ST_EMIT : ST_CLIP;
        end
      end
      ST_CLIP: begin
        if (skip_clip) begin
          state_d = ST_NEXT_CLIP;
        end else if (need_div) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_ITER;
        end
      end
      ST_DIV:       state_d = div_done ? ST_ITER : ST_DIV;
      ST_ITER:      state_d = iter_go ? ST_ITER2 : ST_NEXT_CLIP;
      ST_ITER2:     state_d = ST_ITER3;
      ST_ITER3:     state_d = iter_empty ? ST_NEXT_ITER : ST_BS;
      ST_BS:        state_d = (lo_q < hi_q) ? ST_BS_RD : ST_SCAN;
      ST_BS_RD:     state_d = ST_BS;
      ST_SCAN:      state_d = (k_q < n_q) ? ST_SCAN_RD : ST_NEXT_ITER;
      ST_SCAN_RD:   state_d = in_rng ? ST_KEEP : ST_NEXT_ITER;
      ST_KEEP:      state_d = (rel_ok && srt_sts_i.drop) ? ST_NEXT_CLIP : ST_SCAN;
      ST_NEXT_ITER: state_d = loop_q ? ST_ITER : ST_NEXT_CLIP;
      ST_NEXT_CLIP: state_d = (c_q == LAST_CLIP) ? ST_EMIT : ST_CLIP;
      ST_EMIT:      state_d = ST_WAIT;
      ST_WAIT:      state_d = srt_sts_i.done ? ST_IDLE : ST_WAIT;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o           = (state_q == ST_IDLE) && !q_sts_i.empty;
    tab_we          = pop_o && (cmd_i.op == OP_CLIP);
    mem_we          = pop_o && (cmd_i.op == OP_EVENT);
    div_start       = (state_q == ST_CLIP) && !skip_clip && need_div;
    srt_req_o.clear = pop_o && (cmd_i.op == OP_SCHED);
    srt_req_o.ins   = (state_q == ST_KEEP) && rel_ok;
    srt_req_o.emit  = state_q == ST_EMIT;
    srt_req_o.off   = rel_q[OFFW-1:0];
    srt_req_o.msg   = msg_q;
    slot            = (state_q == ST_BS) ? mid_c : k_q;
    wr_clip         = CW'(cmd_i.clip_slot);
    wr_addr         = AW'(wr_clip) * AW'(EVENTS_PER_CLIP) + AW'(cmd_i.event_slot);
    rd_addr         = AW'(c_q) * AW'(EVENTS_PER_CLIP) + AW'(slot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      if (srt_req_o.clear) begin
        c_q <= '0;
      end else if ((state_q == ST_NEXT_CLIP) && (c_q != LAST_CLIP)) begin
        c_q <= c_q + CW'(1);
      end
    end
  end

  // every clip starts muted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLIPS; i++) begin
        cs_tab_q[i]   <= '0;
        len_tab_q[i]  <= '0;
        loop_tab_q[i] <= 1'b0;
        mute_tab_q[i] <= 1'b1;
        n_tab_q[i]    <= '0;
      end
    end else if (tab_we) begin
      cs_tab_q[wr_clip]   <= cmd_i.position;
      len_tab_q[wr_clip]  <= cmd_i.len;
      loop_tab_q[wr_clip] <= cmd_i.loop_en;
      mute_tab_q[wr_clip] <= cmd_i.mute_en;
      n_tab_q[wr_clip]    <= cmd_i.total;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ev_mem[wr_addr] <= {cmd_i.ev_pos, cmd_i.msg};
    end
    rd_q <= ev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (srt_req_o.clear) begin
          rs_q  <= s2t(cmd_i.position);
          re_q  <= s2t(cmd_i.position) + signed'(TW'(cmd_i.span));
          cnt_q <= cmd_i.span;
        end
      end
      ST_CLIP: begin
        cs_q   <= cs_rd;
        is_q   <= cs_rd;
        len_q  <= u2t(len_tab_q[c_q]);
        loop_q <= loop_tab_q[c_q];
        n_q    <= n_tab_q[c_q];
      end
      ST_DIV: begin
        if (div_done && (div_quo != '0)) begin
          // start one iteration before the first overlapping one
          is_q <= rs_q - u2t(div_rem) - len_q;
        end else if (div_done) begin
          is_q <= cs_q;
        end
      end
      ST_ITER: begin
        d_q <= rs_q - is_q;
        e_q <= re_q - is_q;
      end
      ST_ITER2: begin
        ls_q <= (d_q < 0) ? '0 : d_q;
        if (e_q < 0) begin
          le_q <= '0;
        end else if (e_q > len_q) begin
          le_q <= len_q;
        end else begin
          le_q <= e_q;
        end
      end
      ST_ITER3: begin
        lo_q <= '0;
        hi_q <= n_q;
      end
      ST_BS: begin
        mid_q <= mid_c;
        if (!(lo_q < hi_q)) begin
          k_q <= lo_q;
        end
      end
      ST_BS_RD: begin
        if (eo < ls_q) begin
          lo_q <= mid_q + TOTW'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      ST_SCAN_RD: begin
        rel_q <= eo - d_q;
        msg_q <= rd_q[MSGW-1:0];
      end
      ST_KEEP: begin
        k_q <= k_q + TOTW'(1);
      end
      ST_NEXT_ITER: begin
        is_q <= is_q + len_q;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### design/looped_clip_event_scheduler_top.sv
// top level of the looped clip event scheduler
//
//  channel | direction | handshake               | request
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o | clip write, event write, schedule
//  out     | output    | out_valid_o / out_stall_i | one scheduled event or terminator
//
// writes take effect when the engine pops them from the two entry queue
// a schedule visits each clip (running the loop divider for a looping clip), then each loop iteration
//   (a binary search, then a scan of events), then drains one result per cycle unless out_stall_i holds it
// the iteration count of a looping clip is about span / length + 2, so short loops cost most
// reset leaves all clips muted; event entries hold nothing until written
// the output register lets the engine take the next queued request while a result waits
`timescale 1ns / 1ps
`default_nettype none

module looped_clip_event_scheduler_top import lces_pkg::*; #(
  parameter int NUM_CLIPS        = 8,
  parameter int EVENTS_PER_CLIP  = 256,
  parameter int MAX_BLOCK_EVENTS = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [KINDW-1:0]       kind_i,
  input  wire logic [CSW-1:0]         clip_slot_i,
  input  wire logic [ESW-1:0]         event_slot_i,
  input  wire logic signed [POSW-1:0] position_i,
  input  wire logic [LENW-1:0]        span_i,
  input  wire logic [LENW-1:0]        event_position_i,
  input  wire logic [MSGW-1:0]        event_bytes_i,
  input  wire logic                   loop_enable_i,
  input  wire logic                   mute_enable_i,
  input  wire logic [TOTW-1:0]        event_total_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [MSGW-1:0]             out_message_o,
  output logic [OFFW-1:0]             block_offset_o,
  output logic                        has_event_o,
  output logic                        overflowed_o,
  output logic                        last_o
);

  // classified request into the queue
  cmd_t     push_cmd, q_cmd;
  logic     q_push, q_pop;
  q_sts_t   q_sts;
  // engine to result list
  srt_req_t srt_req;
  srt_sts_t srt_sts;

  lces_front #(
    .NUM_CLIPS       (NUM_CLIPS),
    .EVENTS_PER_CLIP (EVENTS_PER_CLIP)
  ) u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .clip_slot_i      (clip_slot_i),
    .event_slot_i     (event_slot_i),
    .position_i       (position_i),
    .span_i           (span_i),
    .event_position_i (event_position_i),
    .event_bytes_i    (event_bytes_i),
    .loop_enable_i    (loop_enable_i),
    .mute_enable_i    (mute_enable_i),
    .event_total_i    (event_total_i),
    .q_full_i         (q_sts.full),
    .push_o           (q_push),
    .cmd_o            (push_cmd)
  );

  lces_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd),
    .sts_o  (q_sts)
  );

  // engine walks clips, loop iterations and events of one schedule request
  lces_back #(
    .NUM_CLIPS       (NUM_CLIPS),
    .EVENTS_PER_CLIP (EVENTS_PER_CLIP)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (q_cmd),
    .q_sts_i   (q_sts),
    .pop_o     (q_pop),
    .srt_req_o (srt_req),
    .srt_sts_i (srt_sts)
  );

  // capped, offset ordered result list and the output register
  lces_sorter #(
    .MAX_BLOCK_EVENTS (MAX_BLOCK_EVENTS)
  ) u_sorter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (srt_req),
    .sts_o          (srt_sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_message_o  (out_message_o),
    .block_offset_o (block_offset_o),
    .has_event_o    (has_event_o),
    .overflowed_o   (overflowed_o),
    .last_o         (last_o)
  );

  // terminator is always alone and clean
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_event_o |-> last_o && !overflowed_o)
    else $error("terminator without last or with overflow");

  // overflow is only flagged on the final result
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |-> last_o)
    else $error("overflow flag before the final result");

  // a push into an empty queue is visible next cycle
  a_q_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && q_sts.empty |=> !q_sts.empty)
    else $error("queue lost a request");

  // engine never pops an empty queue
  a_q_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_sts.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
